// ===== rtl/bscf_pkg.sv =====
// Shared types and constants for the bone sample cull filter.
package bscf_pkg;
  localparam int unsigned MaxChildren = 8;
  localparam int unsigned SlotW = $clog2(MaxChildren);
  localparam int unsigned CntW = $clog2(MaxChildren + 1);
  localparam int unsigned QDepth = 2;

  typedef enum logic [2:0] {
    REG_MCX = 3'd0,
    REG_MCY = 3'd1,
    REG_MCZ = 3'd2,
    REG_JNT = 3'd3,
    REG_CNT = 3'd4,
    REG_MRG = 3'd5
  } reg_idx_e;

  // word handed from front to back
  typedef struct packed {
    logic signed [18:0] lx;
    logic signed [18:0] ly;
    logic signed [18:0] lz;
    logic signed [18:0] mx;
    logic signed [18:0] my;
    logic signed [18:0] mz;
  } vtx_t;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sh7fff;
    if (v < -20'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic [17:0] absdiff(input logic signed [18:0] a,
                                          input logic signed [18:0] b);
    logic signed [19:0] d;
    d = {a[18], a} - {b[18], b};
    return d[19] ? 18'(-d) : d[17:0];
  endfunction
endpackage

// ===== rtl/bscf_front.sv =====
// Front part: transforms a vertex into the local frame one axis at a time (x, y, then z).
module bscf_front import bscf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic               cmd_i,
  input  logic [2:0]         child_slot_i,
  input  logic signed [15:0] px_i,
  input  logic signed [15:0] py_i,
  input  logic signed [15:0] pz_i,
  input  logic signed [15:0] nx_i,
  input  logic signed [15:0] ny_i,
  input  logic signed [15:0] nz_i,
  input  logic [63:0]        col_x_i,
  input  logic [63:0]        col_y_i,
  input  logic [63:0]        col_z_i,
  input  logic               ld_ok_i,
  output logic               ld_we_o,
  output logic [SlotW-1:0]   ld_slot_o,
  output logic [47:0]        ld_data_o,
  output logic               q_push_o,
  output vtx_t               q_data_o,
  input  logic               q_full_i
);
  logic               busy_q;
  logic [1:0]         cnt_q;
  logic signed [15:0] p_q [3];
  logic signed [15:0] n_q [3];
  logic signed [18:0] l_q [3];
  logic signed [18:0] m_q [3];
  logic [63:0]        col;
  logic signed [35:0] sp, sn;
  logic signed [15:0] c0, c1, c2, tr;
  logic signed [21:0] rp, rn;
  logic               acc;

  // loads wait until no vertex is left ahead of them
  assign stall_o = busy_q || (cmd_i && !ld_ok_i);
  assign acc = valid_i && !stall_o;
  assign ld_we_o = acc && cmd_i && ({1'b0, child_slot_i} < 4'(MaxChildren));
  assign ld_slot_o = SlotW'(child_slot_i);
  assign ld_data_o = {pz_i, py_i, px_i};

  always_comb begin
    case (cnt_q)
      2'd0:    col = col_x_i;
      2'd1:    col = col_y_i;
      default: col = col_z_i;
    endcase
    c0 = col[15:0];
    c1 = col[31:16];
    c2 = col[47:32];
    tr = col[63:48];
    sp = 36'(p_q[0] * c0) + 36'(p_q[1] * c1) + 36'(p_q[2] * c2) + 36'sd8192;
    sn = 36'(n_q[0] * c0) + 36'(n_q[1] * c1) + 36'(n_q[2] * c2) + 36'sd8192;
    rp = sp[35:14];
    rn = sn[35:14];
  end

  assign q_push_o = busy_q && cnt_q == 2'd3 && !q_full_i;
  assign q_data_o = '{lx: l_q[0], ly: l_q[1], lz: l_q[2],
                      mx: m_q[0], my: m_q[1], mz: m_q[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else if (acc && !cmd_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 2'd0;
    end else if (busy_q && cnt_q != 2'd3) begin
      cnt_q <= cnt_q + 2'd1;
    end else if (q_push_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && !cmd_i) begin
      p_q[0] <= px_i; p_q[1] <= py_i; p_q[2] <= pz_i;
      n_q[0] <= nx_i; n_q[1] <= ny_i; n_q[2] <= nz_i;
    end else if (busy_q && cnt_q != 2'd3) begin
      l_q[cnt_q] <= 19'(rp) + 19'(tr);
      m_q[cnt_q] <= 19'(rn);
    end
  end
endmodule

// ===== rtl/bscf_queue.sv =====
// Short queue of transformed vertex words between front and back.
module bscf_queue import bscf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  vtx_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output vtx_t data_o
);
  vtx_t       mem_q [QDepth];
  logic [0:0] wp_q, rp_q;
  logic [1:0] n_q;

  assign full_o = n_q == 2'(QDepth);
  assign empty_o = n_q == 2'd0;
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      n_q  <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      n_q <= n_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue underflow");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= 2'(QDepth)) else $error("queue count");
endmodule

// ===== rtl/bscf_back.sv =====
// Back part: walks child bones one per cycle, then drives the result word.
module bscf_back import bscf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  vtx_t               q_data_i,
  output logic               q_pop_o,
  output logic               idle_o,
  input  logic               ld_we_i,
  input  logic [SlotW-1:0]   ld_slot_i,
  input  logic [47:0]        ld_data_i,
  input  logic [47:0]        joint_i,
  input  logic [3:0]         count_i,
  input  logic [15:0]        margin_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic               keep_o,
  output logic signed [15:0] lx_o,
  output logic signed [15:0] ly_o,
  output logic signed [15:0] lz_o,
  output logic signed [15:0] mx_o,
  output logic signed [15:0] my_o,
  output logic signed [15:0] mz_o
);
  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_e;

  logic [47:0]      ends_q [MaxChildren];
  state_e           st_q;
  logic [CntW-1:0]  k_q, lim;
  logic             cull_q;
  vtx_t             v_q;
  logic             ov_q;
  logic             pv_q;
  logic             fire;
  logic [17:0]      b [3];
  logic [17:0]      va [3];
  logic [35:0]      dot, len2, dot_q, len2_q;
  logic [52:0]      lhs, lo, hi;
  logic             hit;
  logic [47:0]      ce;
  logic signed [18:0] jt [3];

  assign lim = (count_i > 4'(MaxChildren)) ? CntW'(MaxChildren) : CntW'(count_i);
  assign ce = ends_q[k_q[SlotW-1:0]];

  // stage one forms the sums for child k_q, stage two compares them
  always_comb begin
    jt[0] = 19'(signed'(joint_i[15:0]));
    jt[1] = 19'(signed'(joint_i[31:16]));
    jt[2] = 19'(signed'(joint_i[47:32]));
    b[0] = absdiff(19'(signed'(ce[15:0])), jt[0]);
    b[1] = absdiff(19'(signed'(ce[31:16])), jt[1]);
    b[2] = absdiff(19'(signed'(ce[47:32])), jt[2]);
    va[0] = absdiff(v_q.lx, jt[0]);
    va[1] = absdiff(v_q.ly, jt[1]);
    va[2] = absdiff(v_q.lz, jt[2]);
    dot = 36'(va[0] * b[0]) + 36'(va[1] * b[1]) + 36'(va[2] * b[2]);
    len2 = 36'(b[0] * b[0]) + 36'(b[1] * b[1]) + 36'(b[2] * b[2]);
    lhs = {1'b0, dot_q, 16'd0};
    lo = 53'(len2_q) * 53'(margin_i);
    hi = 53'(len2_q) * 53'(17'h10000 - {1'b0, margin_i});
    hit = lhs < lo || lhs > hi;
  end

  assign q_pop_o = st_q == S_IDLE && !q_empty_i && (!ov_q || !stall_i);
  assign idle_o = st_q == S_IDLE;
  assign fire = st_q == S_DONE && (!ov_q || !stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
      pv_q <= 1'b0;
      k_q <= '0;
      cull_q <= 1'b0;
    end else begin
      ov_q <= fire || (ov_q && stall_i);
      unique case (st_q)
        S_IDLE: if (q_pop_o) begin
          st_q <= S_WALK;
          k_q <= '0;
          cull_q <= 1'b0;
          pv_q <= 1'b0;
        end
        S_WALK: begin
          if (cull_q || (k_q >= lim && !pv_q)) st_q <= S_DONE;
          else begin
            if (pv_q && hit) cull_q <= 1'b1;
            if (k_q < lim) k_q <= k_q + 1'b1;
          end
          pv_q <= !cull_q && (k_q < lim);
        end
        S_DONE: if (fire) begin
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_we_i) ends_q[ld_slot_i] <= ld_data_i;
    if (q_pop_o) v_q <= q_data_i;
    if (st_q == S_WALK) begin
      dot_q <= dot;
      len2_q <= len2;
    end
    if (fire) begin
      keep_o <= !cull_q;
      lx_o <= cull_q ? '0 : sat16(20'(v_q.lx));
      ly_o <= cull_q ? '0 : sat16(20'(v_q.ly));
      lz_o <= cull_q ? '0 : sat16(20'(v_q.lz));
      mx_o <= cull_q ? '0 : sat16(20'(v_q.mx));
      my_o <= cull_q ? '0 : sat16(20'(v_q.my));
      mz_o <= cull_q ? '0 : sat16(20'(v_q.mz));
    end
  end

  assign valid_o = ov_q;

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_WALK |-> k_q <= CntW'(MaxChildren)) else $error("walk overrun");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> st_q == S_WALK) else $error("pop not followed by walk");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o) else $error("result dropped");
endmodule

// ===== rtl/bone_sample_cull_filter.sv =====
// Top level of the bone sample cull filter.
// A vertex passes the front, the queue and then the back, which tests it against the child bones.
// The front takes a new vertex only after pushing the last; the back pops one only when idle.
// Load words are accepted once the front, the queue and the back are all idle, else stall.
// Reset (rst_ni low, async) restores the identity matrix and default margin.
// Child table holds no reset value; entries are defined once loaded.
module bone_sample_cull_filter import bscf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic               cmd_i,
  input  logic [2:0]         child_slot_i,
  input  logic signed [15:0] px_i,
  input  logic signed [15:0] py_i,
  input  logic signed [15:0] pz_i,
  input  logic signed [15:0] nx_i,
  input  logic signed [15:0] ny_i,
  input  logic signed [15:0] nz_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic               keep_o,
  output logic signed [15:0] lx_o,
  output logic signed [15:0] ly_o,
  output logic signed [15:0] lz_o,
  output logic signed [15:0] mx_o,
  output logic signed [15:0] my_o,
  output logic signed [15:0] mz_o
);
  logic [63:0] col_x_q, col_y_q, col_z_q;
  logic [47:0] joint_q;
  logic [3:0]  count_q;
  logic [15:0] margin_q;
  logic        ld_we, q_push, q_full, q_pop, q_empty;
  logic        back_idle, ld_ok;
  logic [SlotW-1:0] ld_slot;
  logic [47:0] ld_data;
  vtx_t        q_in, q_out;

  assign cfg_ready_o = 1'b1;
  assign ld_ok = q_empty && back_idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_x_q <= 64'd16384;
      col_y_q <= 64'd16384 << 16;
      col_z_q <= 64'd16384 << 32;
      joint_q <= '0;
      count_q <= '0;
      margin_q <= 16'd6554;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MCX: col_x_q <= cfg_data_i;
        REG_MCY: col_y_q <= cfg_data_i;
        REG_MCZ: col_z_q <= cfg_data_i;
        REG_JNT: joint_q <= cfg_data_i[47:0];
        REG_CNT: count_q <= cfg_data_i[3:0];
        REG_MRG: margin_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  bscf_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .cmd_i, .child_slot_i,
    .px_i, .py_i, .pz_i, .nx_i, .ny_i, .nz_i,
    .col_x_i(col_x_q), .col_y_i(col_y_q), .col_z_i(col_z_q),
    .ld_ok_i(ld_ok),
    .ld_we_o(ld_we), .ld_slot_o(ld_slot), .ld_data_o(ld_data),
    .q_push_o(q_push), .q_data_o(q_in), .q_full_i(q_full)
  );

  bscf_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(q_out)
  );

  bscf_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_data_i(q_out), .q_pop_o(q_pop),
    .idle_o(back_idle),
    .ld_we_i(ld_we), .ld_slot_i(ld_slot), .ld_data_i(ld_data),
    .joint_i(joint_q), .count_i(count_q), .margin_i(margin_q),
    .valid_o, .stall_i, .keep_o, .lx_o, .ly_o, .lz_o, .mx_o, .my_o, .mz_o
  );
endmodule
